// ===== rtl/multi_voice_pcm_mixer_unit_defines.svh =====
// Assertion macros shared by the mixer RTL.
// Each macro expands to a labelled concurrent assertion in simulation and
// to nothing in synthesis.
`ifndef MULTI_VOICE_PCM_MIXER_UNIT_DEFINES_SVH
`define MULTI_VOICE_PCM_MIXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Assertion that is switched off while reset is high.
`define MVPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion that is checked in every cycle, reset included.
`define MVPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MVPM_ASSERT(lbl, clk, rst, prop, msg)
`define MVPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/mvpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mvpm_pkg;

   // Sizing of the mixer.
   localparam int VOICES         = 4;
   localparam int SOUNDS         = 16;
   localparam int LENGTH_BITS    = 20;
   localparam int SAMPLE_BITS    = 8;
   localparam int SOUND_NUM_BITS = 5;
   localparam int SOUND_IDX_BITS = 4;
   localparam int SLOT_BITS      = 2;

   // Offset that turns an unsigned sample into a signed one and back.
   localparam logic [SAMPLE_BITS-1:0] MIX_BIAS = 8'h80;

   // Stream widths, padded to whole bytes.
   localparam int REQ_TDATA_BITS = 64;
   localparam int RSP_TDATA_BITS = 104;
   localparam int REQ_PAD_BITS   = REQ_TDATA_BITS - SOUND_NUM_BITS - LENGTH_BITS
                                   - VOICES * SAMPLE_BITS;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - SAMPLE_BITS - SOUND_NUM_BITS - 1
                                   - SLOT_BITS - VOICES - VOICES * LENGTH_BITS;

   // Kind of a request beat.
   typedef enum logic [1:0] {
      ACT_DEFINE = 2'd0,
      ACT_START  = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_ENGINE_READY = 1'b0,
      CSR_PLAY_ENABLE  = 1'b1
   } csr_index_type;

   // Request payload; the last field declared sits in the lowest bits.
   typedef struct packed {
      logic [REQ_PAD_BITS-1:0]                  pad;
      logic [VOICES-1:0][SAMPLE_BITS-1:0]       voice_sample;
      logic [LENGTH_BITS-1:0]                   sound_length;
      logic [SOUND_NUM_BITS-1:0]                sound_number;
   } req_data_type;

   // Result payload; the last field declared sits in the lowest bits.
   typedef struct packed {
      logic [RSP_PAD_BITS-1:0]                  pad;
      logic [VOICES-1:0][LENGTH_BITS-1:0]       voice_offset;
      logic [VOICES-1:0]                        active_mask;
      logic [SLOT_BITS-1:0]                     start_slot;
      logic                                     start_ok;
      logic [SOUND_NUM_BITS-1:0]                defined_number;
      logic [SAMPLE_BITS-1:0]                   mixed_sample;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== rtl/multi_voice_pcm_mixer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Four-voice 8-bit unsigned PCM mixer with a table of sound lengths.
//
// The req_ stream carries one beat per operation: tuser selects define,
// start or sample tick, tdata carries the sound number, the length of a
// sound being defined and one fetched sample per voice. Every request beat
// yields exactly one rsp_ beat holding the mix, the define and start
// outcome, the active mask and each voice's next fetch offset.
// The csr_ channel writes the engine ready and play enable bits; it is
// always ready and should only be used while the block is empty.
//
// A beat passes an input register and a result register, and its result is
// presented on rsp_ from the result register; one beat per cycle is sustained
// while rsp_tready stays high.
// When rsp_tready is low the result register holds and one more
// request is still taken into the input register; only then does req_tready
// drop. Reset is synchronous: it empties both registers, frees all voices,
// clears the offsets and the sound count, clears engine ready and sets
// play enable. The length table itself is not cleared.
`include "multi_voice_pcm_mixer_unit_defines.svh"

module multi_voice_pcm_mixer_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request stream
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // sound_number[4:0], sound_length[24:5], voice0..3_sample[56:25], zero pad
   input  wire  [mvpm_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // action[1:0]
   input  wire  [1:0]                           req_tuser,
   // Result stream
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // mixed_sample[7:0], defined_number[12:8], start_ok[13], start_slot[15:14],
   // active_mask[19:16], voice0..3_offset[99:20], zero pad
   output logic [mvpm_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   // Configuration writes
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  mvpm_pkg::csr_index_type        csr_index,
   input  wire                                  csr_wdata
);
   import mvpm_pkg::*;

   // Pipeline registers and handshake.
   logic                          in_valid_ff;
   action_type                    in_action_ff;
   req_data_type                  in_data_ff;
   logic                          out_valid_ff;
   rsp_data_type                  out_ff;
   logic                          out_space;
   logic                          fire;

   // Configuration.
   logic                          engine_ready_ff;
   logic                          play_enable_ff;

   // Voice and sound state.
   logic [VOICES-1:0]             voice_active_ff;
   logic [VOICES-1:0]             voice_active_in;
   logic [LENGTH_BITS-1:0]        voice_length_ff [VOICES];
   logic [LENGTH_BITS-1:0]        voice_length_in [VOICES];
   logic [LENGTH_BITS-1:0]        voice_offset_ff [VOICES];
   logic [LENGTH_BITS-1:0]        voice_offset_in [VOICES];
   logic [LENGTH_BITS-1:0]        sound_table_ff  [SOUNDS];
   logic [SOUND_NUM_BITS-1:0]     sound_count_ff;
   logic [SOUND_NUM_BITS-1:0]     sound_count_in;

   // Datapath helpers.
   logic                          table_we;
   logic [SOUND_IDX_BITS-1:0]     table_rd_idx;
   logic [SOUND_NUM_BITS-1:0]     start_num_m1;
   logic [LENGTH_BITS-1:0]        start_length;
   logic                          slot_found;
   logic [SAMPLE_BITS-1:0]        mix_acc;
   rsp_data_type                  rsp_in;

   // The input register may be refilled whenever its beat moves on.
   assign out_space  = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_space;
   assign req_tready = !in_valid_ff || out_space;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign csr_ready  = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready) begin
         in_action_ff <= action_type'(req_tuser);
         in_data_ff   <= req_data_type'(req_tdata);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_space) begin
         out_valid_ff <= in_valid_ff;
      end
      if (fire) begin
         out_ff <= rsp_in;
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         engine_ready_ff <= 1'b0;
         play_enable_ff  <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENGINE_READY: engine_ready_ff <= csr_wdata;
            CSR_PLAY_ENABLE:  play_enable_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Length lookup for a start: sound numbers count from one.
   assign start_num_m1 = in_data_ff.sound_number - SOUND_NUM_BITS'(1);
   assign table_rd_idx = start_num_m1[SOUND_IDX_BITS-1:0];
   assign start_length = sound_table_ff[table_rd_idx];

   // Next voice state and the result for the beat in the input register.
   always_comb begin
      voice_active_in = voice_active_ff;
      voice_length_in = voice_length_ff;
      voice_offset_in = voice_offset_ff;
      sound_count_in  = sound_count_ff;
      table_we        = 1'b0;
      slot_found      = 1'b0;
      mix_acc         = '0;
      rsp_in          = '0;
      rsp_in.mixed_sample = MIX_BIAS;

      unique case (in_action_ff)
         ACT_DEFINE: begin
            if (engine_ready_ff && (sound_count_ff < SOUND_NUM_BITS'(SOUNDS))) begin
               table_we              = 1'b1;
               sound_count_in        = sound_count_ff + SOUND_NUM_BITS'(1);
               rsp_in.defined_number = sound_count_in;
            end
         end
         ACT_START: begin
            if (engine_ready_ff && play_enable_ff
                && (in_data_ff.sound_number != '0)
                && (in_data_ff.sound_number <= sound_count_ff)) begin
               // The lowest free slot takes the sound.
               for (int v = 0; v < VOICES; v++) begin
                  if (!slot_found && !voice_active_ff[v]) begin
                     slot_found         = 1'b1;
                     voice_active_in[v] = 1'b1;
                     voice_length_in[v] = start_length;
                     voice_offset_in[v] = '0;
                     rsp_in.start_slot  = SLOT_BITS'(v);
                  end
               end
               rsp_in.start_ok = slot_found;
            end
         end
         ACT_TICK: begin
            // Each playing voice with samples left adds its signed sample and steps on; the
            // sum wraps at eight bits.
            for (int v = 0; v < VOICES; v++) begin
               if (voice_active_ff[v]) begin
                  if (voice_offset_ff[v] < voice_length_ff[v]) begin
                     mix_acc = mix_acc + (in_data_ff.voice_sample[v] ^ MIX_BIAS);
                     voice_offset_in[v] = voice_offset_ff[v] + LENGTH_BITS'(1);
                  end
                  if (voice_offset_in[v] >= voice_length_ff[v]) begin
                     voice_active_in[v] = 1'b0;
                  end
               end
            end
            rsp_in.mixed_sample = mix_acc ^ MIX_BIAS;
         end
         ACT_NOP: ;
         default: ;
      endcase

      rsp_in.active_mask = voice_active_in;
      for (int v = 0; v < VOICES; v++) begin
         rsp_in.voice_offset[v] = voice_offset_in[v];
      end
   end

   // Voice state and sound count.
   always_ff @(posedge clock) begin
      if (reset) begin
         voice_active_ff <= '0;
         sound_count_ff  <= '0;
         for (int v = 0; v < VOICES; v++) begin
            voice_length_ff[v] <= '0;
            voice_offset_ff[v] <= '0;
         end
      end else if (fire) begin
         voice_active_ff <= voice_active_in;
         sound_count_ff  <= sound_count_in;
         voice_length_ff <= voice_length_in;
         voice_offset_ff <= voice_offset_in;
      end
   end

   // Sound length table, rounded down to a multiple of four samples.
   always_ff @(posedge clock) begin
      if (fire && table_we) begin
         sound_table_ff[sound_count_ff[SOUND_IDX_BITS-1:0]] <=
            in_data_ff.sound_length & ~LENGTH_BITS'(3);
      end
   end

   // Checks on the pipeline and the allocation logic.
   `MVPM_ASSERT(a_count_in_range, clock, reset,
      sound_count_ff <= SOUND_NUM_BITS'(SOUNDS), "sound count beyond table size")
   `MVPM_ASSERT(a_start_slot_active, clock, reset,
      (out_valid_ff && out_ff.start_ok) |-> out_ff.active_mask[out_ff.start_slot],
      "granted start slot not shown active")
   `MVPM_ASSERT(a_define_matches_count, clock, reset,
      (out_valid_ff && (out_ff.defined_number != '0))
         |-> (sound_count_ff == out_ff.defined_number),
      "defined number differs from sound count")
   `MVPM_ASSERT_ALWAYS(a_stall_only_when_full, clock,
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready),
      "request stalled while a register was free")

endmodule

`default_nettype wire

// ===== tb/sv/mix_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and register channels of the mixer, keeps its
// own copy of the voice and sound state, and compares every result beat with
// the oldest predicted one.
module mix_result_checker
   import mvpm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [REQ_TDATA_BITS-1:0]   req_tdata,
   input  logic [1:0]                  req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  csr_index_type               csr_index,
   input  logic                        csr_wdata,
   output int                          results_pending,
   output int                          failures
);

   // Register copies.
   logic                   engine_on;
   logic                   play_on;

   // Voice slots and the table of sound lengths.
   logic [VOICES-1:0]      voice_busy;
   logic [LENGTH_BITS-1:0] voice_len [VOICES];
   logic [LENGTH_BITS-1:0] voice_pos [VOICES];
   logic [LENGTH_BITS-1:0] sound_len [SOUNDS];
   int                     sounds_defined;

   // Results still owed by the block, oldest first.
   rsp_data_type           mix_results_due [$];
   int                     result_index = 0;
   int                     fail_count = 0;
   int                     pending_count = 0;

   assign failures        = fail_count;
   assign results_pending = pending_count;

   // Applies one request beat to the state copy and returns the result it owes.
   function automatic rsp_data_type predict_mix(input action_type act,
                                                input req_data_type d);
      rsp_data_type            r;
      logic [SAMPLE_BITS-1:0]  acc;
      int                      v;
      r = '0;
      r.mixed_sample = MIX_BIAS;
      case (act)
         ACT_DEFINE: begin
            if (engine_on && sounds_defined < SOUNDS) begin
               // Lengths are kept rounded down to a multiple of four samples.
               sound_len[sounds_defined] = d.sound_length & ~LENGTH_BITS'(3);
               sounds_defined++;
               r.defined_number = SOUND_NUM_BITS'(sounds_defined);
            end
         end
         ACT_START: begin
            if (engine_on && play_on && d.sound_number != '0
                && int'(d.sound_number) <= sounds_defined) begin
               // The lowest free slot takes the sound.
               for (v = 0; v < VOICES; v++) begin
                  if (!voice_busy[v] && !r.start_ok) begin
                     voice_len[v]  = sound_len[SOUND_IDX_BITS'(d.sound_number - 1'b1)];
                     voice_pos[v]  = '0;
                     voice_busy[v] = 1'b1;
                     r.start_ok    = 1'b1;
                     r.start_slot  = SLOT_BITS'(v);
                  end
               end
            end
         end
         ACT_TICK: begin
            // Sum of signed samples wraps in eight bits, then is biased back.
            acc = '0;
            for (v = 0; v < VOICES; v++) begin
               if (voice_busy[v]) begin
                  if (voice_pos[v] < voice_len[v]) begin
                     acc = acc + d.voice_sample[v] - MIX_BIAS;
                     voice_pos[v] = voice_pos[v] + 1'b1;
                  end
                  if (voice_pos[v] >= voice_len[v]) begin
                     voice_busy[v] = 1'b0;
                  end
               end
            end
            r.mixed_sample = acc + MIX_BIAS;
         end
         default: begin
         end
      endcase
      r.active_mask = voice_busy;
      for (v = 0; v < VOICES; v++) begin
         r.voice_offset[v] = voice_pos[v];
      end
      return r;
   endfunction

   // Compares one field and reports the first few differences.
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         if (fail_count < 10) begin
            $display("Result %0d, %s: expected %0d, got %0d",
                     result_index, field, want, got);
         end
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      rsp_data_type got;
      int           v;
      if (reset) begin
         engine_on      = 1'b0;
         play_on        = 1'b1;
         voice_busy     = '0;
         sounds_defined = 0;
         for (v = 0; v < VOICES; v++) begin
            voice_len[v] = '0;
            voice_pos[v] = '0;
         end
         mix_results_due.delete();
      end else begin
         // Register writes change only the copies of the two bits.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENGINE_READY: engine_on = csr_wdata;
               default:          play_on   = csr_wdata;
            endcase
         end

         // A result beat is checked before any request taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_data_type'(rsp_tdata);
            if (mix_results_due.size() == 0) begin
               if (fail_count < 10) begin
                  $display("Result %0d arrived with nothing predicted: %h",
                           result_index, rsp_tdata);
               end
               fail_count++;
            end else begin
               want = mix_results_due.pop_front();
               check_field("mixed_sample", 32'(want.mixed_sample),
                           32'(got.mixed_sample));
               check_field("defined_number", 32'(want.defined_number),
                           32'(got.defined_number));
               check_field("start_ok", 32'(want.start_ok), 32'(got.start_ok));
               check_field("start_slot", 32'(want.start_slot), 32'(got.start_slot));
               check_field("active_mask", 32'(want.active_mask),
                           32'(got.active_mask));
               for (v = 0; v < VOICES; v++) begin
                  check_field($sformatf("voice%0d_offset", v),
                              32'(want.voice_offset[v]), 32'(got.voice_offset[v]));
               end
            end
            result_index++;
         end

         if (req_tvalid && req_tready) begin
            mix_results_due.push_back(predict_mix(action_type'(req_tuser),
                                                  req_data_type'(req_tdata)));
         end
      end
      pending_count <= mix_results_due.size();
   end

endmodule

// ===== tb/sv/tb_multi_voice_pcm_mixer_unit.sv =====
`timescale 1ns / 1ps

module tb_multi_voice_pcm_mixer_unit;
   import mvpm_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 6;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_TDATA_BITS-1:0]   req_tdata = '0;
   logic [1:0]                  req_tuser = ACT_NOP;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   csr_index_type               csr_index = CSR_ENGINE_READY;
   logic                        csr_wdata = 1'b0;
   int                          results_pending;
   int                          failures;

   // Sender bursts and receiver stall pattern.
   int                          burst_left = 0;
   logic                        hold_request = 1'b0;
   logic                        hold_taken = 1'b0;
   int                          hold_left = 0;
   int                          mode_left = 0;
   int                          stall_mode = 0;
   int                          cycle_count = 0;

   // What the stimulus needs to know of the block's settings.
   logic                        ready_setting = 1'b0;
   int                          sounds_accepted = 0;
   int                          beats_by_action [4] = '{0, 0, 0, 0};

   multi_voice_pcm_mixer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mix_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .results_pending (results_pending),
      .failures        (failures)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: one long hold-off on request, otherwise a changing stall pattern.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(10, 60);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles.", CYCLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Ends a burst now and then with a random gap.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
   endtask

   // Offers one request beat and waits until it is taken.
   task automatic send_beat(input action_type act,
                            input logic [SOUND_NUM_BITS-1:0] num,
                            input logic [LENGTH_BITS-1:0] len,
                            input logic [VOICES*SAMPLE_BITS-1:0] samples);
      req_data_type beat;
      pace_sender();
      beat              = '0;
      beat.sound_number = num;
      beat.sound_length = len;
      beat.voice_sample = samples;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      beats_by_action[act]++;
      if (act == ACT_DEFINE && ready_setting && sounds_accepted < SOUNDS) begin
         sounds_accepted++;
      end
   endtask

   // Stops sending and waits until every owed result has come out.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only once the block is empty.
   task automatic write_register(input csr_index_type idx, input logic val);
      drain_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ENGINE_READY) begin
         ready_setting = val;
      end
   endtask

   // Mostly ticks and starts of valid sounds, with some defines, bad numbers
   // and no-ops mixed in.
   task automatic random_items(input int count);
      int                            pick;
      logic [SOUND_NUM_BITS-1:0]     num;
      logic [LENGTH_BITS-1:0]        len;
      logic [VOICES*SAMPLE_BITS-1:0] samples;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         // Sound 1 is very long and would hold a voice for the rest of the run.
         num = SOUND_NUM_BITS'($urandom_range(2, SOUNDS));
         if ($urandom_range(0, 7) == 0) begin
            num = SOUND_NUM_BITS'($urandom_range(0, 31));
            if (num == 5'd1) begin
               num = '0;
            end
         end
         // Short sounds while the table fills; any length once defines are refused.
         if (ready_setting && sounds_accepted < SOUNDS) begin
            len = LENGTH_BITS'($urandom_range(0, 24));
         end else begin
            len = LENGTH_BITS'($urandom);
         end
         samples = $urandom;
         if (pick < 8) begin
            send_beat(ACT_DEFINE, num, len, samples);
         end else if (pick < 30) begin
            send_beat(ACT_START, num, len, samples);
         end else if (pick < 96) begin
            send_beat(ACT_TICK, num, len, samples);
         end else begin
            send_beat(ACT_NOP, num, len, samples);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Engine not ready yet: define and start are refused, ticks still mix.
      send_beat(ACT_DEFINE, '0, '1, '0);
      send_beat(ACT_START, 5'd1, '0, '0);
      send_beat(ACT_TICK, '0, '0, '1);
      send_beat(ACT_NOP, '1, '1, '1);

      write_register(CSR_ENGINE_READY, 1'b1);

      // Longest length, zero, then lengths that round down.
      send_beat(ACT_DEFINE, '0, '1, '0);
      send_beat(ACT_DEFINE, '0, 20'd0, '0);
      send_beat(ACT_DEFINE, '0, 20'd3, '0);
      send_beat(ACT_DEFINE, '0, 20'd5, '0);
      send_beat(ACT_DEFINE, '0, 20'd10, '0);
      // Number zero, a number past the table and one past the defined count.
      send_beat(ACT_START, 5'd0, '0, '0);
      send_beat(ACT_START, 5'd31, '0, '0);
      send_beat(ACT_START, 5'd6, '0, '0);
      // Fill all four slots, with zero-length sounds in two of them.
      send_beat(ACT_START, 5'd2, '0, '0);
      send_beat(ACT_START, 5'd4, '0, '0);
      send_beat(ACT_START, 5'd5, '0, '0);
      send_beat(ACT_START, 5'd3, '0, '0);
      // No slot left.
      send_beat(ACT_START, 5'd4, '0, '0);
      // Sample extremes; the zero-length voices go free on the first tick.
      send_beat(ACT_TICK, '0, '0, '0);
      send_beat(ACT_TICK, '0, '0, '1);
      send_beat(ACT_TICK, '0, '0, 32'h01FF_8001);
      send_beat(ACT_NOP, '0, '0, '0);

      random_items(300);

      // Play disabled: starts are refused and the voices drain.
      write_register(CSR_PLAY_ENABLE, 1'b0);
      random_items(150);

      // Engine stopped again: defines and starts refused, mixing continues.
      write_register(CSR_PLAY_ENABLE, 1'b1);
      write_register(CSR_ENGINE_READY, 1'b0);
      random_items(150);

      // Back to normal; the receiver holds off for a while early in this phase.
      write_register(CSR_ENGINE_READY, 1'b1);
      hold_request <= 1'b1;
      send_beat(ACT_START, 5'd1, '0, '0);
      random_items(280);

      drain_block();
      $display("Covered %0d define, %0d start, %0d tick and %0d no-op beats",
               beats_by_action[ACT_DEFINE], beats_by_action[ACT_START],
               beats_by_action[ACT_TICK], beats_by_action[ACT_NOP]);
      $display("over five register settings, with one %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
